// File: rtl/core/lz4_frame_output_bound_core_defines.svh
// ----------------------------------------------------------------------------
// LZ4 frame output bound - assertion macros
// Shared concurrent assertion forms. The asserting module provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef LZ4_FRAME_OUTPUT_BOUND_CORE_DEFINES_SVH
`define LZ4_FRAME_OUTPUT_BOUND_CORE_DEFINES_SVH

// same-cycle implication
`define LZ4FOB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LZ4FOB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lz4fob_pkg.sv
// ----------------------------------------------------------------------------
// LZ4 frame output bound - package
// Word types, walk phases, status codes and block size table.
// ----------------------------------------------------------------------------
package lz4fob_pkg;

  // input word: one frame body byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // result word: one per frame
  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] result_size;
    logic        size_exact;
  } out_word_t;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_DATA,
    PH_BCHK,
    PH_CCHK,
    PH_DONE
  } phase_t;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_IN_HDR     = 3'd1;
  localparam status_t ST_OVERSIZE   = 3'd2;
  localparam status_t ST_IN_BLOCK   = 3'd3;
  localparam status_t ST_IN_BCHK    = 3'd4;
  localparam status_t ST_IN_CCHK    = 3'd5;
  localparam status_t ST_TRAILING   = 3'd6;
  localparam status_t ST_OVER_BOUND = 3'd7;

  // config register indexes
  localparam logic [1:0] CFG_BLOCK_SIZE_CODE     = 2'd0;
  localparam logic [1:0] CFG_BLOCK_CHECKSUM_ON   = 2'd1;
  localparam logic [1:0] CFG_CONTENT_CHECKSUM_ON = 2'd2;
  localparam logic [1:0] CFG_DECLARED_SIZE       = 2'd3;

  localparam int LEFT_W = 23;                 // holds up to 4 MiB
  localparam logic [LEFT_W-1:0] CHK_LEN = 23'd4;
  localparam int RAW_BIT = 31;
  localparam logic [30:0] EXPANSION = 31'd255;

  // block add event from the walker to the accumulator
  typedef struct packed {
    logic              add_vld;
    logic [LEFT_W-1:0] add_amt;
    status_t           status;   // status after this byte
  } walk_ev_t;

  function automatic logic [LEFT_W-1:0] blk_max(input logic [1:0] code);
    logic [LEFT_W-1:0] m;
    case (code)
      2'd0:    m = 23'd65536;
      2'd1:    m = 23'd262144;
      2'd2:    m = 23'd1048576;
      default: m = 23'd4194304;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/core/lz4fob_walker.sv
// ----------------------------------------------------------------------------
// LZ4 frame output bound - block walker
// Per-byte phase tracking: block headers, data skip, checksums, error latch.
// ----------------------------------------------------------------------------
`include "lz4_frame_output_bound_core_defines.svh"

module lz4fob_walker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  lz4fob_pkg::in_word_t  in_data,
  input  logic [1:0]            blk_code,
  input  logic                  bchk_on,
  input  logic                  cchk_on,
  output lz4fob_pkg::walk_ev_t  ev
);
  import lz4fob_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic [31:0]       hs_r, hs_nxt;
  logic [LEFT_W-1:0] left_r, left_nxt;
  status_t           err_r, err_nxt;

  logic [31:0]       hdr_word;
  logic [30:0]       hdr_size;
  logic [LEFT_W-1:0] maxb;
  logic              oversize;
  logic [30:0]       expand;
  logic              hdr_end;
  logic              take;

  // header arrives little-endian: shift in from the top
  assign hdr_word = {in_data.data_byte, hs_r[31:8]};
  assign hdr_size = hdr_word[30:0];
  assign maxb     = blk_max(blk_code);
  assign oversize = hdr_size > 31'(maxb);
  assign expand   = 31'(hdr_size[LEFT_W-1:0]) * EXPANSION;
  assign take     = acc && (err_r == ST_OK);
  assign hdr_end  = take && (phase_r == PH_HEADER) && (idx_r == 2'd3);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    hs_nxt    = hs_r;
    left_nxt  = left_r;
    err_nxt   = err_r;
    if (take) begin
      unique case (phase_r)
        PH_HEADER: begin
          idx_nxt = idx_r + 2'd1;
          hs_nxt  = hdr_word;
          if (idx_r == 2'd3) begin
            hs_nxt = '0;
            if (hdr_word == 32'd0) begin
              if (cchk_on) begin
                phase_nxt = PH_CCHK;
                left_nxt  = CHK_LEN;
              end else begin
                phase_nxt = PH_DONE;
              end
            end else if (oversize) begin
              err_nxt = ST_OVERSIZE;
            end else if (hdr_size == 31'd0) begin
              if (bchk_on) begin
                phase_nxt = PH_BCHK;
                left_nxt  = CHK_LEN;
              end
            end else begin
              phase_nxt = PH_DATA;
              left_nxt  = hdr_size[LEFT_W-1:0];
            end
          end
        end
        PH_DATA: begin
          left_nxt = left_r - LEFT_W'(1);
          if (left_r == LEFT_W'(1)) begin
            if (bchk_on) begin
              phase_nxt = PH_BCHK;
              left_nxt  = CHK_LEN;
            end else begin
              phase_nxt = PH_HEADER;
            end
          end
        end
        PH_BCHK: begin
          left_nxt = left_r - LEFT_W'(1);
          if (left_r == LEFT_W'(1)) phase_nxt = PH_HEADER;
        end
        PH_CCHK: begin
          left_nxt = left_r - LEFT_W'(1);
          if (left_r == LEFT_W'(1)) phase_nxt = PH_DONE;
        end
        PH_DONE: begin
          err_nxt = ST_TRAILING;
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end
  end

  // outputs: bound increment and status after this byte
  always_comb begin
    ev.add_vld = hdr_end && (hdr_word != 32'd0) && !oversize;
    if (hdr_word[RAW_BIT]) begin
      ev.add_amt = hdr_size[LEFT_W-1:0];
    end else if (expand < 31'(maxb)) begin
      ev.add_amt = expand[LEFT_W-1:0];
    end else begin
      ev.add_amt = maxb;
    end
    if (err_nxt != ST_OK) begin
      ev.status = err_nxt;
    end else begin
      unique case (phase_nxt)
        PH_HEADER: ev.status = ST_IN_HDR;
        PH_DATA:   ev.status = ST_IN_BLOCK;
        PH_BCHK:   ev.status = ST_IN_BCHK;
        PH_CCHK:   ev.status = ST_IN_CCHK;
        default:   ev.status = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_data.last_byte)) begin
      phase_r <= PH_HEADER;
      idx_r   <= '0;
      hs_r    <= '0;
      left_r  <= '0;
      err_r   <= ST_OK;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      hs_r    <= hs_nxt;
      left_r  <= left_nxt;
      err_r   <= err_nxt;
    end
  end

  `LZ4FOB_ASSERT_NEXT(a_err_latch, (err_r != ST_OK) && !(acc && in_data.last_byte), err_r == $past(err_r), "latched error changed mid-frame")
  `LZ4FOB_ASSERT_NOW(a_idx_hdr, idx_r != 2'd0, phase_r == PH_HEADER, "header byte index outside header phase")
  `LZ4FOB_ASSERT_NOW(a_left_live, (phase_r == PH_DATA) || (phase_r == PH_BCHK) || (phase_r == PH_CCHK), left_r != '0, "byte count empty in a counting phase")

endmodule

// File: rtl/core/lz4_frame_output_bound_core.sv
// ----------------------------------------------------------------------------
// LZ4 frame output bound - top level
// Walks an LZ4 frame body byte by byte and reports the decompressed size bound.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one frame-body byte per word (after the frame header), last_byte
//            flags the final byte of the buffer. Accepted when in_valid and
//            !in_stall.
//   out_*  : one result word per frame, produced only for a last_byte word:
//            status, result_size (bound or declared size) and size_exact.
//   cfg_*  : plain register writes (block size code, checksum flags, declared
//            content size); write only while no frame is in flight.
// Throughput: one byte per cycle while in_stall is low. The per-byte walker
//   and the registered bound accumulator never hold off a byte.
// Result: registered, valid in the cycle after the last byte is taken.
// Stall: a waiting result does not block body bytes; only a new last byte is
//   held off while the previous result still sits stalled in the out register.
// Reset: walker state, bound sum, output valid and config registers clear.
//   After each last byte the walker returns to its start state; config stays.
// ----------------------------------------------------------------------------
`include "lz4_frame_output_bound_core_defines.svh"

module lz4_frame_output_bound_core #(
  parameter int BOUND_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // byte input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lz4fob_pkg::in_word_t   in_data,
  // result output
  output logic                   out_valid,
  input  logic                   out_stall,
  output lz4fob_pkg::out_word_t  out_data,
  // config writes
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [63:0]            cfg_wdata
);
  import lz4fob_pkg::*;

  localparam logic [BOUND_BITS-1:0] BOUND_CAP = '1;

  // config registers
  logic [1:0]  cfg_code_r;
  logic        cfg_bchk_r;
  logic        cfg_cchk_r;
  logic [63:0] cfg_decl_r;

  // accumulator
  logic                  pend_vld_r;
  logic [LEFT_W-1:0]     pend_amt_r;
  logic [BOUND_BITS-1:0] bound_r, bound_nxt;
  logic [BOUND_BITS:0]   sum_ext;

  // result register
  logic      out_vld_r;
  out_word_t out_r, out_nxt;

  logic     in_acc;
  logic     frame_end;
  logic     decl_over;
  walk_ev_t ev;

  // only a last byte needs the out register free
  assign in_stall  = out_vld_r && out_stall && in_data.last_byte;
  assign in_acc    = in_valid && !in_stall;
  assign frame_end = in_acc && in_data.last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_code_r <= '0;
      cfg_bchk_r <= 1'b0;
      cfg_cchk_r <= 1'b0;
      cfg_decl_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_SIZE_CODE:     cfg_code_r <= cfg_wdata[1:0];
        CFG_BLOCK_CHECKSUM_ON:   cfg_bchk_r <= cfg_wdata[0];
        CFG_CONTENT_CHECKSUM_ON: cfg_cchk_r <= cfg_wdata[0];
        CFG_DECLARED_SIZE:       cfg_decl_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lz4fob_walker u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .in_data  (in_data),
    .blk_code (cfg_code_r),
    .bchk_on  (cfg_bchk_r),
    .cchk_on  (cfg_cchk_r),
    .ev       (ev)
  );

  // block increment is staged, then added to bound_r; the sum is only read
  // at a clean frame end, at least four bytes after the last block header
  assign sum_ext   = {1'b0, bound_r} + (BOUND_BITS+1)'(pend_amt_r);
  assign bound_nxt = sum_ext[BOUND_BITS] ? BOUND_CAP : sum_ext[BOUND_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n || frame_end) begin
      pend_vld_r <= 1'b0;
      bound_r    <= '0;
    end else begin
      pend_vld_r <= in_acc && ev.add_vld;
      if (pend_vld_r) bound_r <= bound_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && ev.add_vld) pend_amt_r <= ev.add_amt;
  end

  // result word
  assign decl_over = cfg_decl_r > 64'(bound_r);

  always_comb begin
    out_nxt.status      = ev.status;
    out_nxt.result_size = '0;
    out_nxt.size_exact  = 1'b0;
    if (ev.status == ST_OK) begin
      if (cfg_decl_r == 64'd0) begin
        out_nxt.result_size = 48'(bound_r);
      end else if (decl_over) begin
        out_nxt.status = ST_OVER_BOUND;
      end else begin
        out_nxt.result_size = cfg_decl_r[47:0];
        out_nxt.size_exact  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (frame_end) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_end) out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `LZ4FOB_ASSERT_NEXT(a_bound_mono, !frame_end, bound_r >= $past(bound_r), "bound sum went down mid-frame")
  `LZ4FOB_ASSERT_NOW(a_exact_ok, out_vld_r && out_r.size_exact, out_r.status == ST_OK, "exact size with error status")
  `LZ4FOB_ASSERT_NOW(a_err_zero, out_vld_r && (out_r.status != ST_OK), (out_r.result_size == '0) && !out_r.size_exact, "error result carries a size")

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ4 frame output bound - testbench
// Streams frame bodies into the walker and checks every result word against
// a cycle-free model of the block walk: directed corner frames first, then
// random well-formed, cut, padded, oversized and noise frames under three
// idle mixes, then a long result hold that backs up the byte input.
// ----------------------------------------------------------------------------
module testbench;
  import lz4fob_pkg::*;

  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int DRAIN_LIMIT = 2000;  // cycles to wait for outstanding results

  typedef enum int {FR_CLEAN, FR_CUT, FR_TRAIL, FR_OVERSIZE, FR_NOISE} frame_kind_t;

  // clock, reset and DUT-facing signals; driven ones known from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  lz4_frame_output_bound_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Walk model: register copies plus the per-frame walk state
  // --------------------------------------------------------------------------
  logic [1:0]        m_code = '0;
  logic              m_bchk = 1'b0;
  logic              m_cchk = 1'b0;
  logic [63:0]       m_declared = '0;

  phase_t            walk_phase = PH_HEADER;
  int unsigned       hdr_count = 0;
  logic [31:0]       hdr_word = '0;
  logic [LEFT_W-1:0] left_bytes = '0;
  logic [47:0]       bound_acc = '0;
  status_t           walk_err = ST_OK;

  out_word_t         expected_results[$];

  // run bookkeeping
  int mismatches = 0;
  int words_sent = 0;
  int frames_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_request = 0;

  // frame under construction
  logic [7:0]  frame_bytes[$];
  logic [63:0] frame_bound;

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  // 64 KiB times 4^code
  function automatic logic [31:0] block_limit(input logic [1:0] code);
    return 32'h0001_0000 << (2 * code);
  endfunction

  // bound sum saturates at 2^48 - 1
  function automatic logic [47:0] bound_add(input logic [47:0] acc, input logic [63:0] amt);
    logic [48:0] s;
    s = {1'b0, acc} + amt[48:0];
    return s[48] ? '1 : s[47:0];
  endfunction

  function automatic void end_of_block();
    if (m_bchk) begin
      walk_phase = PH_BCHK;
      left_bytes = CHK_LEN;
    end else begin
      walk_phase = PH_HEADER;
    end
  endfunction

  function automatic void walk_restart();
    walk_phase = PH_HEADER;
    hdr_count  = 0;
    hdr_word   = '0;
    left_bytes = '0;
    bound_acc  = '0;
    walk_err   = ST_OK;
  endfunction

  // one accepted byte word; pushes the expected result on a last byte
  function automatic void predict_word(input in_word_t w);
    logic [31:0] hdr;
    logic [31:0] lim;
    logic [31:0] sz;
    logic [63:0] amt;
    out_word_t   r;
    status_t     st;
    if (walk_err == ST_OK) begin
      case (walk_phase)
        PH_HEADER: begin
          hdr_word = hdr_word | (32'(w.data_byte) << (8 * hdr_count));
          hdr_count++;
          if (hdr_count == 4) begin
            hdr = hdr_word;
            hdr_count = 0;
            hdr_word = '0;
            lim = block_limit(m_code);
            if (hdr == 32'h0) begin
              // end mark
              if (m_cchk) begin
                walk_phase = PH_CCHK;
                left_bytes = CHK_LEN;
              end else begin
                walk_phase = PH_DONE;
              end
            end else begin
              sz = {1'b0, hdr[30:0]};
              if (sz > lim) begin
                walk_err = ST_OVERSIZE;
              end else begin
                if (hdr[RAW_BIT]) begin
                  amt = 64'(sz);
                end else begin
                  amt = 64'(sz) * 64'd255;
                  if (amt > 64'(lim)) amt = 64'(lim);
                end
                bound_acc = bound_add(bound_acc, amt);
                if (sz == 0) begin
                  end_of_block();
                end else begin
                  walk_phase = PH_DATA;
                  left_bytes = sz[LEFT_W-1:0];
                end
              end
            end
          end
        end
        PH_DATA: begin
          left_bytes--;
          if (left_bytes == 0) end_of_block();
        end
        PH_BCHK: begin
          left_bytes--;
          if (left_bytes == 0) walk_phase = PH_HEADER;
        end
        PH_CCHK: begin
          left_bytes--;
          if (left_bytes == 0) walk_phase = PH_DONE;
        end
        default: walk_err = ST_TRAILING;
      endcase
    end
    if (w.last_byte) begin
      st = walk_err;
      r = '0;
      if (st == ST_OK) begin
        case (walk_phase)
          PH_HEADER: st = ST_IN_HDR;
          PH_DATA:   st = ST_IN_BLOCK;
          PH_BCHK:   st = ST_IN_BCHK;
          PH_CCHK:   st = ST_IN_CCHK;
          default:   st = ST_OK;
        endcase
      end
      if (st == ST_OK) begin
        if (m_declared == 64'h0) begin
          r.result_size = bound_acc;
        end else if (m_declared > {16'h0, bound_acc}) begin
          st = ST_OVER_BOUND;
        end else begin
          r.result_size = m_declared[47:0];
          r.size_exact  = 1'b1;
        end
      end
      r.status = st;
      expected_results.push_back(r);
      walk_restart();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // one byte word; optional idle cycles before it, held until taken
  task automatic send_word(input logic [7:0] b, input logic last);
    in_word_t w;
    w.data_byte = b;
    w.last_byte = last;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(w);
    words_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_word(frame_bytes[i], i == frame_bytes.size() - 1);
    frames_sent++;
  endtask

  // all four registers back to back; only while the walker is idle
  task automatic set_config(input logic [1:0] code, input logic bchk, input logic cchk,
                            input logic [63:0] decl);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BLOCK_SIZE_CODE;
    cfg_wdata <= 64'(code);
    @(posedge clk);
    cfg_index <= CFG_BLOCK_CHECKSUM_ON;
    cfg_wdata <= 64'(bchk);
    @(posedge clk);
    cfg_index <= CFG_CONTENT_CHECKSUM_ON;
    cfg_wdata <= 64'(cchk);
    @(posedge clk);
    cfg_index <= CFG_DECLARED_SIZE;
    cfg_wdata <= decl;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_code     = code;
    m_bchk     = bchk;
    m_cchk     = cchk;
    m_declared = decl;
    cfg_writes += 4;
  endtask

  // wait for every outstanding result, then let the pipeline settle
  task automatic drain_results();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected result words never arrived",
                                expected_results.size()));
      expected_results.delete();
    end
    repeat (3) @(posedge clk);
  endtask

  function automatic void push_word32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) frame_bytes.push_back(v[8*i +: 8]);
  endfunction

  // builds frame_bytes for the given settings; frame_bound is the clean bound
  task automatic build_frame(input frame_kind_t kind, input logic [1:0] code,
                             input logic bchk, input logic cchk);
    int          nblk;
    int          bad_at;
    int          len;
    int          r;
    logic [31:0] lim;
    logic [31:0] sz;
    logic        raw;
    logic [63:0] amt;
    frame_bytes.delete();
    frame_bound = '0;
    lim = block_limit(code);
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
      return;
    end
    nblk   = $urandom_range(0, 3);
    bad_at = (kind == FR_OVERSIZE) ? $urandom_range(0, nblk) : -1;
    for (int b = 0; b <= nblk; b++) begin
      if (b == bad_at) push_word32({1'($urandom_range(1)), 31'($urandom_range(lim + 1, 32'h7FFF_FFFF))});
      if (b < nblk) begin
        r = $urandom_range(99);
        if (r < 3) sz = $urandom_range(250, 260);   // straddles the 64 KiB clamp of code 0
        else if (r < 12) sz = 0;
        else sz = $urandom_range(1, 12);
        raw = (sz == 0) ? 1'b1 : 1'($urandom_range(1));  // compressed size 0 is the end mark
        push_word32({raw, sz[30:0]});
        repeat (sz) frame_bytes.push_back(8'($urandom));
        if (bchk) push_word32($urandom);
        amt = raw ? 64'(sz) : 64'(sz) * 64'd255;
        if (!raw && amt > 64'(lim)) amt = 64'(lim);
        frame_bound += amt;
      end
    end
    push_word32(32'h0);
    if (cchk) push_word32($urandom);
    if (kind == FR_CUT) begin
      len = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
    end else if (kind == FR_TRAIL) begin
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall, or a long counted hold when one is requested
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_stall_gen
    int hold_seen;
    int hold_left;
    if (hold_request != hold_seen) begin
      hold_seen = hold_request;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: oldest expectation against each accepted result word
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result word with none expected");
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_data.status, want.status));
        if (out_data.result_size !== want.result_size)
          report_mismatch($sformatf("result_size got %0h want %0h",
                                    out_data.result_size, want.result_size));
        if (out_data.size_exact !== want.size_exact)
          report_mismatch($sformatf("size_exact got %0b want %0b",
                                    out_data.size_exact, want.size_exact));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // short hand-built frames, reset config except the checksum one
  task automatic test_directed_frames();
    tx_idle_pct = 10;
    rx_idle_pct = 51;
    frame_bytes = {8'h00, 8'h00, 8'h00, 8'h00};         // bare end mark, bound 0
    send_frame();
    frame_bytes = {8'h5A};                              // ends in a block header
    send_frame();
    frame_bytes = {8'hFF, 8'hFF, 8'hFF, 8'hFF};         // all-ones header: oversized
    send_frame();
    frame_bytes = {8'h00, 8'h00, 8'h01, 8'h80};         // raw block at max size, cut
    send_frame();
    frame_bytes = {8'h00, 8'h00, 8'h00, 8'h00, 8'h07};  // byte after the frame end
    send_frame();
    drain_results();
    set_config(2'd0, 1'b1, 1'b0, 64'h0);
    frame_bytes = {8'h00, 8'h00, 8'h00, 8'h80, 8'h11, 8'h22};  // empty block, cut in checksum
    send_frame();
    drain_results();
  endtask

  // random frames; a fresh setting per round, extremes in the first rounds
  task automatic test_random_frames(input int tx_pct, input int rx_pct, input int n_words);
    int          start_words;
    int          round;
    int          r;
    logic [1:0]  code;
    logic        bchk;
    logic        cchk;
    logic [63:0] decl;
    frame_kind_t kind;
    tx_idle_pct  = tx_pct;
    rx_idle_pct  = rx_pct;
    start_words  = words_sent;
    round = 0;
    while (words_sent - start_words < n_words) begin
      case (round)
        0:       begin code = 2'd3; bchk = 1'b1; cchk = 1'b1; end
        1:       begin code = 2'd0; bchk = 1'b0; cchk = 1'b0; end
        default: begin
          code = 2'($urandom_range(3));
          bchk = 1'($urandom_range(1));
          cchk = 1'($urandom_range(1));
        end
      endcase
      r = $urandom_range(99);
      if (r < 70) kind = FR_CLEAN;
      else if (r < 80) kind = FR_CUT;
      else if (r < 87) kind = FR_TRAIL;
      else if (r < 94) kind = FR_OVERSIZE;
      else kind = FR_NOISE;
      build_frame(kind, code, bchk, cchk);
      // declared size relative to the clean bound of the first frame
      r = $urandom_range(99);
      if (round == 2) decl = '1;
      else if (r < 30) decl = 64'h0;
      else if (r < 50) decl = frame_bound;
      else if (r < 65) decl = frame_bound + 64'd1;
      else if (r < 80) decl = (frame_bound > 1) ? 64'($urandom_range(1, frame_bound)) : frame_bound;
      else if (r < 90) decl = {$urandom, $urandom};
      else decl = $urandom_range(1) ? '1 : (64'h1 << 48);
      drain_results();
      set_config(code, bchk, cchk, decl);
      send_frame();
      if ($urandom_range(1)) begin
        build_frame(FR_CLEAN, code, bchk, cchk);
        send_frame();
      end
      round++;
    end
    drain_results();
  endtask

  // receiver holds off while short frames keep coming: input must back up
  task automatic test_result_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(2'd1, 1'b0, 1'b0, 64'h0);
    hold_request++;
    repeat (8) begin
      frame_bytes = {8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00};
      send_frame();
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_random_frames(10, 51, 230);
    test_random_frames(51, 10, 230);
    test_random_frames(0, 0, 230);
    test_result_backpressure();
    $display("summary: %0d byte words in %0d frames, %0d result words checked, %0d cfg writes",
             words_sent, frames_sent, results_seen, cfg_writes);
    $display("summary: directed corners, random frames under three idle mixes, long result hold");
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
